// ===== rtl/teh_pkg.sv =====
package teh_pkg;

    localparam int TIME_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [TIME_BITS-1:0]  event_time;
        logic [FIELD_BITS-1:0] event_word;
    } t_in_req;

    typedef struct packed {
        logic                  found;
        logic [TIME_BITS-1:0]  found_time;
        logic [FIELD_BITS-1:0] found_word;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out_req;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic                 ins;
        logic [TIME_BITS-1:0] ins_time;
        logic [TIME_BITS-1:0] key;
    } t_teh_cmd;

    // Shift link from one cell to the cell below it.
    typedef struct packed {
        logic                 le;
        logic [TIME_BITS-1:0] tim;
    } t_teh_link;

    // Query chain link, carried from the top cell toward the bottom.
    typedef struct packed {
        logic                 hit;
        logic [TIME_BITS-1:0] tim;
    } t_teh_hit;

endpackage

// ===== rtl/time_ordered_event_history.sv =====
// Time-ordered event history: a table of DEPTH events kept sorted newest first.
// Requests enter on i_in / i_in_valid and are accepted at a clock edge where
// i_in_valid is high and o_in_stall is low. Results leave on o_out / o_out_valid
// and are taken at an edge where o_out_valid is high and i_out_stall is low.
// Every request gives exactly one result, in request order.
// An insert updates all cells in the accepting cycle; its result (entry count
// after the insert) is valid in the next cycle, and the next request may follow
// right away. A query lets a match token ripple through the cell chain one
// cell per cycle, and the block takes no new request during that walk; its
// result is registered once the walk has reached the bottom cell.
// A synchronous active-low reset clears every slot to zero, the entry count
// to zero and drops any pending result. While the receiver stalls, the result
// register holds; a request is still taken if its result can go into the
// register as the old one leaves, otherwise o_in_stall stays high.
module time_ordered_event_history #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  teh_pkg::t_in_req  i_in,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output teh_pkg::t_out_req o_out,
    output logic              o_out_valid,
    input  logic              i_out_stall
);
    import teh_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_scan, n_scan;
    logic [TIME_BITS-1:0] r_key;
    t_out_req            r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic w_accept;
    logic w_ins;
    logic w_query;
    logic w_out_free;
    logic w_scan_done;

    t_teh_cmd             w_cmd;
    logic [DEPTH-1:0]     w_slot_valid;
    t_teh_link            w_link   [DEPTH];
    logic [WORD_BITS-1:0] w_word   [DEPTH];
    t_teh_hit             w_q      [DEPTH];
    logic [WORD_BITS-1:0] w_q_word [DEPTH];

    logic [WORD_BITS+FIELD_BITS-1:0] w_in_word_ext;
    logic [WORD_BITS+FIELD_BITS-1:0] w_out_word_ext;
    logic [CNT_W+COUNT_BITS-1:0]     w_ins_cnt_ext;
    logic [CNT_W+COUNT_BITS-1:0]     w_cur_cnt_ext;

    // The result register is free when empty or when it is drained this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ins      = w_accept && (i_in.func == FUNC_INSERT);
    assign w_query    = w_accept && (i_in.func == FUNC_QUERY);

    assign w_scan_done = (r_state == ST_SCAN) && (r_scan == CNT_W'(DEPTH)) && w_out_free;

    // Only the low WORD_BITS of the payload are stored; results are zero-extended.
    assign w_in_word_ext  = (WORD_BITS + FIELD_BITS)'(i_in.event_word);
    assign w_out_word_ext = (WORD_BITS + FIELD_BITS)'(w_q_word[DEPTH-1]);

    assign w_cmd.ins      = w_ins;
    assign w_cmd.ins_time = i_in.event_time;
    assign w_cmd.key      = r_key;

    assign n_count = (w_ins && (r_count != CNT_W'(DEPTH))) ? r_count + CNT_W'(1) : r_count;

    // The entry count field carries the low bits of the count.
    assign w_ins_cnt_ext = (CNT_W + COUNT_BITS)'(n_count);
    assign w_cur_cnt_ext = (CNT_W + COUNT_BITS)'(r_count);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_teh_link            w_up;
            logic [WORD_BITS-1:0] w_up_word;
            t_teh_hit             w_q_up;
            logic [WORD_BITS-1:0] w_q_up_word;

            assign w_slot_valid[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                // Nothing shifts into the top slot, and the query chain
                // starts from a not-found token.
                assign w_up        = '0;
                assign w_up_word   = '0;
                assign w_q_up      = '0;
                assign w_q_up_word = '0;
            end else begin : g_body
                assign w_up        = w_link[gi-1];
                assign w_up_word   = w_word[gi-1];
                assign w_q_up      = w_q[gi-1];
                assign w_q_up_word = w_q_word[gi-1];
            end

            teh_cell #(
                .WORD_BITS (WORD_BITS),
                .LAST      (gi == DEPTH - 1)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_slot_valid (w_slot_valid[gi]),
                .i_new_word   (w_in_word_ext[WORD_BITS-1:0]),
                .i_up         (w_up),
                .i_up_word    (w_up_word),
                .o_link       (w_link[gi]),
                .o_word       (w_word[gi]),
                .i_q_up       (w_q_up),
                .i_q_up_word  (w_q_up_word),
                .o_q          (w_q[gi]),
                .o_q_word     (w_q_word[gi])
            );
        end
    endgenerate

    // Control sequencer. A query holds the key stable while r_scan counts up to
    // DEPTH, so that the token at the bottom of the chain has seen every cell.
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_SCAN;
                    n_scan  = '0;
                end
            end
            ST_SCAN: begin
                if (r_scan != CNT_W'(DEPTH)) begin
                    n_scan = r_scan + CNT_W'(1);
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_ins) begin
            n_out.found       = 1'b0;
            n_out.found_time  = '0;
            n_out.found_word  = '0;
            n_out.entry_count = w_ins_cnt_ext[COUNT_BITS-1:0];
            n_out_valid       = 1'b1;
        end else if (w_scan_done) begin
            n_out.found       = w_q[DEPTH-1].hit;
            n_out.found_time  = w_q[DEPTH-1].tim;
            n_out.found_word  = w_out_word_ext[FIELD_BITS-1:0];
            n_out.entry_count = w_cur_cnt_ext[COUNT_BITS-1:0];
            n_out_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_query) begin
            r_key <= i_in.event_time;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> r_out_valid && !r_out.found)
        else $error("insert did not present its result");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_state == ST_SCAN) && (r_scan == '0))
        else $error("query did not start the chain walk");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_accept)
        else $error("request accepted during a query walk");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_done |=> r_out_valid && (r_state == ST_IDLE))
        else $error("query walk ended without a result");
`endif

endmodule

// ===== rtl/teh_cell.sv =====
module teh_cell #(
    parameter int WORD_BITS = 32,
    parameter bit LAST      = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  teh_pkg::t_teh_cmd     i_cmd,
    input  logic                  i_slot_valid,
    input  logic [WORD_BITS-1:0]  i_new_word,
    input  teh_pkg::t_teh_link    i_up,
    input  logic [WORD_BITS-1:0]  i_up_word,
    output teh_pkg::t_teh_link    o_link,
    output logic [WORD_BITS-1:0]  o_word,
    input  teh_pkg::t_teh_hit     i_q_up,
    input  logic [WORD_BITS-1:0]  i_q_up_word,
    output teh_pkg::t_teh_hit     o_q,
    output logic [WORD_BITS-1:0]  o_q_word
);
    import teh_pkg::*;

    logic [TIME_BITS-1:0] r_time, n_time;
    logic [WORD_BITS-1:0] r_word, n_word;
    t_teh_hit             r_q, n_q;
    logic [WORD_BITS-1:0] r_q_word, n_q_word;
    logic                 w_le;
    logic                 w_match;

    assign w_le    = (r_time <= i_cmd.ins_time);
    assign w_match = i_slot_valid && (r_time >= i_cmd.key);

    assign o_link.le  = w_le;
    assign o_link.tim = r_time;
    assign o_word     = r_word;
    assign o_q        = r_q;
    assign o_q_word   = r_q_word;

    // The cell above moves down when it is not newer than the new event;
    // otherwise the gap opens here if this entry is not newer either, or in the last cell.
    always_comb begin
        n_time = r_time;
        n_word = r_word;
        if (i_cmd.ins) begin
            if (i_up.le) begin
                n_time = i_up.tim;
                n_word = i_up_word;
            end else if (w_le || LAST) begin
                n_time = i_cmd.ins_time;
                n_word = i_new_word;
            end
        end
    end

    // The lowest matching cell wins because it overrides what came from above.
    always_comb begin
        if (w_match) begin
            n_q.hit  = 1'b1;
            n_q.tim  = r_time;
            n_q_word = r_word;
        end else begin
            n_q      = i_q_up;
            n_q_word = i_q_up_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_word <= '0;
        end else begin
            r_time <= n_time;
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_q_word <= n_q_word;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Bench for the time-ordered event history. Requests go in on one
// valid/stall channel and results come back on another, one result per
// request, in order. A shadow copy of the sorted table in this file predicts
// every result but those written by hand on typed script rows. Each result is
// checked field by field against the oldest prediction still waiting.
module tb_top;
    import teh_pkg::*;

    localparam int DEPTH           = 16;
    localparam int ITEMS_PER_PHASE = 225;
    // A query walks the whole cell chain and nothing is accepted meanwhile.
    // Random stalls and gaps add to that. This is many times the longest
    // quiet stretch that a correct block shows.
    localparam int QUIET_LIMIT     = 1000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    t_in_req  in_req    = '0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_out_req out_req;
    logic     out_valid;
    logic     out_stall = 1'b0;

    // How often, in percent, the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Shadow of the event table. Slot 0 holds the newest event.
    logic [TIME_BITS-1:0]  shadow_time [DEPTH];
    logic [FIELD_BITS-1:0] shadow_word [DEPTH];
    int                    shadow_count;

    // Predicted results of accepted requests, oldest first.
    t_out_req answers_due[$];
    int       mismatches = 0;

    // A row of the directed script. On typed rows the result is written out
    // by hand: those are inserts and misses, with an entry count that is
    // obvious. All other rows use the shadow table.
    typedef struct {
        t_in_req               req;
        bit                    typed;
        logic [COUNT_BITS-1:0] count;
    } t_script_row;

    t_script_row script_rows[$];

    always #5 clk = ~clk;

    time_ordered_event_history #(
        .DEPTH     (DEPTH),
        .WORD_BITS (FIELD_BITS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_req),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .o_out       (out_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall)
    );

    // Apply one request to the shadow table and return its result. An insert
    // moves every slot whose time is at most the new time down by one place.
    // Empty slots hold zero and move like any other slot. The new event takes
    // the gap, so it sits above older events that have the same time. A query
    // scans the valid slots from the oldest upward for a time at or above the
    // key.
    function automatic t_out_req history_step(t_in_req req);
        t_out_req res;
        int       pos;
        int       n;
        res = '0;
        if (req.func == FUNC_INSERT) begin
            pos = DEPTH - 1;
            while (pos > 0 && shadow_time[pos - 1] <= req.event_time) begin
                shadow_time[pos] = shadow_time[pos - 1];
                shadow_word[pos] = shadow_word[pos - 1];
                pos--;
            end
            shadow_time[pos] = req.event_time;
            shadow_word[pos] = req.event_word;
            if (shadow_count < DEPTH) begin
                shadow_count++;
            end
        end else begin
            for (n = shadow_count - 1; n >= 0 && !res.found; n--) begin
                if (shadow_time[n] >= req.event_time) begin
                    res.found      = 1'b1;
                    res.found_time = shadow_time[n];
                    res.found_word = shadow_word[n];
                end
            end
        end
        res.entry_count = COUNT_BITS'(shadow_count);
        return res;
    endfunction

    task automatic add_row(input logic func, input logic [TIME_BITS-1:0] stamp,
                           input logic [FIELD_BITS-1:0] word, input bit typed,
                           input logic [COUNT_BITS-1:0] count);
        t_script_row row;
        row.req.func       = func;
        row.req.event_time = stamp;
        row.req.event_word = word;
        row.typed          = typed;
        row.count          = count;
        script_rows.push_back(row);
    endtask

    // Offer one request and return at the edge where it is accepted. A random
    // gap may come first. Valid is dropped only when a gap is taken, so valid
    // never gets two assignments in one time step.
    task automatic send_req(input t_in_req req);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_req   <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Result side: take and check results, and stall at random. All values
    // are read at the edge before any nonblocking update lands.
    always @(posedge clk) begin : result_check
        t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (answers_due.size() == 0) begin
                $display("%0t: result with no request waiting: %h", $time, out_req);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                if (out_req.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, out_req.found);
                    mismatches++;
                end
                if (out_req.found_time !== want.found_time) begin
                    $display("%0t: found_time expected %h actual %h",
                             $time, want.found_time, out_req.found_time);
                    mismatches++;
                end
                if (out_req.found_word !== want.found_word) begin
                    $display("%0t: found_word expected %h actual %h",
                             $time, want.found_word, out_req.found_word);
                    mismatches++;
                end
                if (out_req.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, out_req.entry_count);
                    mismatches++;
                end
            end
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_in_req               req;
        t_out_req              want;
        logic [TIME_BITS-1:0]  stamp;
        int                    i;
        int                    k;
        int                    phase;
        int                    pick;

        for (i = 0; i < DEPTH; i++) begin
            shadow_time[i] = '0;
            shadow_word[i] = '0;
        end
        shadow_count = 0;

        // Queries on the empty table find nothing, whatever the key.
        add_row(FUNC_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 5'd0);
        add_row(FUNC_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 5'd0);
        // The lowest time, then hits and misses around it.
        add_row(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd1);
        add_row(FUNC_QUERY,  32'h0000_0000, 32'h1234_5678, 1'b0, 5'd0);
        add_row(FUNC_QUERY,  32'h0000_0001, 32'h0000_0000, 1'b0, 5'd0);
        // The highest time and payload, then an equal time on top of it.
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd2);
        add_row(FUNC_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 5'd0);
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 5'd3);
        add_row(FUNC_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd0);
        add_row(FUNC_QUERY,  32'h8000_0000, 32'h0000_0000, 1'b0, 5'd0);
        // A second zero time goes above the first one.
        add_row(FUNC_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, 5'd4);
        add_row(FUNC_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
        // Fill the table past its depth so that the count saturates and the
        // oldest entry falls off.
        for (k = 1; k <= 13; k++) begin
            stamp = k * 32'h1357_9BDF;
            add_row(FUNC_INSERT, stamp, ~stamp, 1'b1,
                    (4 + k > DEPTH) ? COUNT_BITS'(DEPTH) : COUNT_BITS'(4 + k));
        end
        add_row(FUNC_QUERY,  32'h0000_0002, 32'h0000_0000, 1'b0, 5'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i]) begin
            send_req(script_rows[i].req);
            want = history_step(script_rows[i].req);
            if (script_rows[i].typed) begin
                want = '0;
                want.entry_count = script_rows[i].count;
            end
            answers_due.push_back(want);
        end

        // Random requests over four handshake phases: free flow, sender gaps,
        // receiver stalls, and both at a light rate.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                req.func       = (pick < 40) ? FUNC_QUERY : FUNC_INSERT;
                req.event_word = $urandom();
                // Times cluster on the extremes, on a small range where equal
                // times are common, and next to times in the table, so that
                // queries hit exactly, just above and just below an entry.
                case ($urandom_range(9))
                    0:       req.event_time = '0;
                    1:       req.event_time = '1;
                    2, 3:    req.event_time = $urandom_range(15);
                    4, 5:    req.event_time = $urandom();
                    default: req.event_time = shadow_time[$urandom_range(DEPTH - 1)]
                                              + $urandom_range(2) - 1;
                endcase
                send_req(req);
                answers_due.push_back(history_step(req));
            end
        end
        in_valid <= 1'b0;

        while (answers_due.size() != 0) @(posedge clk);
        // Allow for a stray late result.
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
